@@ rtl/spf_pkg.sv @@
// Package for the scanline polygon fill unit.
// Holds operation codes, the sequencer state type and fixed widths.
// No dependencies.
package spf_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_WALK,
      ST_EMIT
   } state_type;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_LINE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam int COORD_W   = 10;
   localparam int MAX_SPANS = 32;
   localparam int SPAN_CNT_W = 6;

endpackage

@@ rtl/spf_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameter; used by the fill unit for slopes.
module spf_div #(
   parameter int DVD_W = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [9:0]       divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   localparam int CW = $clog2(DVD_W + 1);

   logic [10:0]      rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [9:0]       dsr_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [10:0]      trial;

   always_comb begin
      trial   = {rem_ff[9:0], quo_ff[DVD_W-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign done     = busy_ff && (cnt_ff == CW'(1));
   assign quotient = quo_in;

endmodule

@@ rtl/spf_sort.sv @@
// Insertion sorter: a row of cells kept in ascending signed order.
// Inserts one value a cycle, drains two from the head a cycle.
// No dependencies beyond its parameters.
module spf_sort #(
   parameter int DEPTH = 64,
   parameter int XW    = 27
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 insert,
   input  logic signed [XW-1:0] ins_x,
   input  logic                 shift2,
   output logic signed [XW-1:0] head0,
   output logic signed [XW-1:0] head1,
   output logic                 pair_ok,
   output logic                 more_ok
);
   logic signed [XW-1:0] cell_ff [DEPTH+1];
   logic signed [XW-1:0] cell_in [DEPTH+1];
   logic [DEPTH+1:0]     occ_ff, occ_in;
   logic [DEPTH:0]       gt;

   always_comb begin
      for (int j = 0; j <= DEPTH; j++) begin
         gt[j] = !occ_ff[j] || (cell_ff[j] > ins_x);
      end
      occ_in = occ_ff;
      for (int j = 0; j <= DEPTH; j++) begin
         cell_in[j] = cell_ff[j];
      end
      if (clear) begin
         occ_in = '0;
      end else if (insert) begin
         occ_in = {occ_ff[DEPTH:0], 1'b1};
         if (gt[0]) begin
            cell_in[0] = ins_x;
         end
         for (int j = 1; j <= DEPTH; j++) begin
            if (gt[j]) begin
               cell_in[j] = gt[j-1] ? cell_ff[j-1] : ins_x;
            end
         end
      end else if (shift2) begin
         occ_in = {2'b00, occ_ff[DEPTH+1:2]};
         for (int j = 0; j <= DEPTH - 2; j++) begin
            cell_in[j] = cell_ff[j+2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
      for (int j = 0; j <= DEPTH; j++) begin
         cell_ff[j] <= cell_in[j];
      end
   end

   assign head0   = cell_ff[0];
   assign head1   = cell_ff[1];
   assign pair_ok = occ_ff[1];
   assign more_ok = occ_ff[3];

endmodule

@@ rtl/scanline_polygon_fill_unit.sv @@
// Scanline polygon fill unit: edge store, working-x memory and span sequencer.
// Depends on spf_pkg, spf_div and spf_sort.
//
//   chan | dir | handshake           | payload
//   req  | in  | req_valid/req_stall | operation, x_start, y_start, x_end, y_end
//   rsp  | out | rsp_valid/rsp_stall | scanline, span_left/right, span_valid, last, overflow
//
// Add: the serial slope divider forms the edge slope before the edge is stored.
// Line: a walk through the edge store in memory order, then one span item per
// cycle while rsp is not stalled (at most 32 items).
// Clear empties the edge store. Reset is synchronous and needs no memory pass.
// A stalled rsp item holds in the output register; the walk never waits on it.
module scanline_polygon_fill_unit #(
   parameter int MAX_EDGES  = 64,
   parameter int SCAN_LINES = 1024,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [9:0]  req_x_start,
   input  logic [9:0]  req_y_start,
   input  logic [9:0]  req_x_end,
   input  logic [9:0]  req_y_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_scanline,
   output logic [9:0]  rsp_span_left,
   output logic [9:0]  rsp_span_right,
   output logic        rsp_span_valid,
   output logic        rsp_last,
   output logic        rsp_overflow
);
   localparam int XW     = 11 + FRAC_BITS;
   localparam int DVD_W  = 10 + FRAC_BITS;
   localparam int IDX_W  = $clog2(MAX_EDGES);
   localparam int CNT_W  = $clog2(MAX_EDGES + 1);
   localparam int LINE_W = $clog2(SCAN_LINES);
   localparam int CMP_W  = LINE_W + 10;
   localparam int ENT_W  = 30 + XW;
   localparam int SW     = spf_pkg::SPAN_CNT_W;

   spf_pkg::state_type state_ff, state_in;

   // edge store entry: {low y, high y, low x, slope}
   logic [ENT_W-1:0] store_mem [MAX_EDGES];
   logic [ENT_W-1:0] store_q;
   logic [XW-1:0]    work_mem [MAX_EDGES];
   logic [XW-1:0]    work_q;

   logic [MAX_EDGES-1:0] active_ff, active_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [LINE_W-1:0]    line_ff, line_in;
   logic                 ovf_ff, ovf_in;

   logic [9:0]  ly_ff, hy_ff, lx_ff;
   logic        neg_ff;
   logic [CNT_W-1:0] rd_ff, rd_in;
   logic        pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff;
   logic [SW-1:0] k_ff, k_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [9:0]  o_left_ff, o_right_ff, o_line_ff, o_left_in, o_right_in;
   logic        o_sv_ff, o_last_ff, o_ovf_ff, o_sv_in, o_last_in;
   logic        o_load;

   logic        req_acc;
   logic        div_start, div_done;
   logic [DVD_W-1:0] div_q, dividend;
   logic [9:0]  abs_dx, dy;
   logic        edge_ok;

   logic [9:0]  e_ly, e_hy, e_lx;
   logic [XW-1:0] e_slope, cur_x, nxt_x, slope_v;
   logic        e_start, act_new, rd_issue;
   logic        s_clear, s_insert, s_shift;
   logic signed [XW-1:0] head0, head1;
   logic        pair_ok, more_ok, emit_pair, emit_last, can_load;
   logic [LINE_W:0] line_inc;
   logic [CMP_W-1:0] line_ext;

   assign req_acc  = req_valid && !req_stall;
   assign line_ext = CMP_W'(line_ff);
   assign line_inc = {1'b0, line_ff} + 1'b1;

   // endpoint ordering and divider operands
   always_comb begin
      if (req_y_start < req_y_end) begin
         abs_dx = (req_x_end >= req_x_start) ? req_x_end - req_x_start
                                             : req_x_start - req_x_end;
         dy     = req_y_end - req_y_start;
      end else begin
         abs_dx = (req_x_start >= req_x_end) ? req_x_start - req_x_end
                                             : req_x_end - req_x_start;
         dy     = req_y_start - req_y_end;
      end
      dividend = DVD_W'(abs_dx) << FRAC_BITS;
      edge_ok  = (req_y_start != req_y_end) && (cnt_ff < CNT_W'(MAX_EDGES));
   end

   spf_div #(.DVD_W(DVD_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (dy),
      .done     (div_done),
      .quotient (div_q)
   );

   // unpack the entry being walked
   always_comb begin
      e_ly    = store_q[ENT_W-1 -: 10];
      e_hy    = store_q[ENT_W-11 -: 10];
      e_lx    = store_q[ENT_W-21 -: 10];
      e_slope = store_q[XW-1:0];
      e_start = (CMP_W'(e_ly) == line_ext);
      cur_x   = e_start ? (XW'(e_lx) << FRAC_BITS) : work_q;
      act_new = (active_ff[pidx_ff] || e_start) && (CMP_W'(e_hy) != line_ext);
      nxt_x   = cur_x + e_slope;
      slope_v = neg_ff ? XW'(0) - XW'(div_q) : XW'(div_q);
   end

   assign emit_pair = pair_ok && (k_ff < SW'(spf_pkg::MAX_SPANS));
   assign emit_last = !(more_ok && (k_ff + 1'b1 < SW'(spf_pkg::MAX_SPANS)));
   assign can_load  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spf_pkg::ST_IDLE: begin
            if (req_acc && req_operation == spf_pkg::OP_ADD && edge_ok) begin
               state_in = spf_pkg::ST_DIV;
            end else if (req_acc && req_operation == spf_pkg::OP_LINE) begin
               state_in = spf_pkg::ST_WALK;
            end
         end
         spf_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = spf_pkg::ST_IDLE;
            end
         end
         spf_pkg::ST_WALK: begin
            if (rd_ff == cnt_ff && !pend_ff) begin
               state_in = spf_pkg::ST_EMIT;
            end
         end
         spf_pkg::ST_EMIT: begin
            if (can_load && (!emit_pair || emit_last)) begin
               state_in = spf_pkg::ST_IDLE;
            end
         end
         default: state_in = spf_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = (state_ff != spf_pkg::ST_IDLE);
      div_start = 1'b0;
      rd_issue  = 1'b0;
      s_clear   = 1'b0;
      s_insert  = 1'b0;
      s_shift   = 1'b0;
      o_load    = 1'b0;
      active_in = active_ff;
      cnt_in    = cnt_ff;
      line_in   = line_ff;
      ovf_in    = ovf_ff;
      rd_in     = rd_ff;
      pend_in   = 1'b0;
      k_in      = k_ff;
      o_left_in = '0;
      o_right_in = '0;
      o_sv_in   = 1'b0;
      o_last_in = 1'b0;
      unique case (state_ff)
         spf_pkg::ST_IDLE: begin
            rd_in = '0;
            k_in  = '0;
            if (req_acc) begin
               priority if (req_operation == spf_pkg::OP_ADD) begin
                  if (req_y_start != req_y_end && !edge_ok) begin
                     ovf_in = 1'b1;
                  end
                  div_start = edge_ok;
               end else if (req_operation == spf_pkg::OP_LINE) begin
                  s_clear = 1'b1;
               end else if (req_operation == spf_pkg::OP_CLEAR) begin
                  active_in = '0;
                  cnt_in    = '0;
                  line_in   = '0;
                  ovf_in    = 1'b0;
               end else begin
                  ovf_in = ovf_ff;
               end
            end
         end
         spf_pkg::ST_DIV: begin
            if (div_done) begin
               active_in[cnt_ff[IDX_W-1:0]] = 1'b0;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         spf_pkg::ST_WALK: begin
            if (rd_ff != cnt_ff) begin
               rd_issue = 1'b1;
               pend_in  = 1'b1;
               rd_in    = rd_ff + 1'b1;
            end
            if (pend_ff) begin
               active_in[pidx_ff] = act_new;
               s_insert = act_new;
            end
         end
         spf_pkg::ST_EMIT: begin
            if (can_load) begin
               o_load = 1'b1;
               if (emit_pair) begin
                  o_left_in  = head0[XW-1] ? 10'd0 : head0[FRAC_BITS+9:FRAC_BITS];
                  o_right_in = head1[XW-1] ? 10'd0 : head1[FRAC_BITS+9:FRAC_BITS];
                  o_sv_in    = 1'b1;
                  o_last_in  = emit_last;
                  s_shift    = 1'b1;
                  k_in       = k_ff + 1'b1;
               end else begin
                  o_last_in = 1'b1;
               end
               if (!emit_pair || emit_last) begin
                  line_in = (line_inc >= (LINE_W+1)'(SCAN_LINES)) ? '0
                                                                  : line_inc[LINE_W-1:0];
               end
            end
         end
         default: ;
      endcase
      rsp_valid_in = o_load || (rsp_valid_ff && rsp_stall);
   end

   spf_sort #(.DEPTH(MAX_EDGES), .XW(XW)) u_sort (
      .clock   (clock),
      .reset   (reset),
      .clear   (s_clear),
      .insert  (s_insert),
      .ins_x   (cur_x),
      .shift2  (s_shift),
      .head0   (head0),
      .head1   (head1),
      .pair_ok (pair_ok),
      .more_ok (more_ok)
   );

   // memories: one read port each, registered data
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         store_q <= store_mem[rd_ff[IDX_W-1:0]];
         work_q  <= work_mem[rd_ff[IDX_W-1:0]];
      end
      if (state_ff == spf_pkg::ST_DIV && div_done) begin
         store_mem[cnt_ff[IDX_W-1:0]] <= {ly_ff, hy_ff, lx_ff, slope_v};
      end
      // advance the working x; the entry is not read again this line
      if (state_ff == spf_pkg::ST_WALK && pend_ff && act_new) begin
         work_mem[pidx_ff] <= nxt_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spf_pkg::ST_IDLE;
         active_ff    <= '0;
         cnt_ff       <= '0;
         line_ff      <= '0;
         ovf_ff       <= 1'b0;
         rd_ff        <= '0;
         pend_ff      <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         line_ff      <= line_in;
         ovf_ff       <= ovf_in;
         rd_ff        <= rd_in;
         pend_ff      <= pend_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rd_issue) begin
         pidx_ff <= rd_ff[IDX_W-1:0];
      end
      if (div_start) begin
         // hold the lower endpoint first
         if (req_y_start < req_y_end) begin
            ly_ff  <= req_y_start;
            hy_ff  <= req_y_end;
            lx_ff  <= req_x_start;
            neg_ff <= req_x_end < req_x_start;
         end else begin
            ly_ff  <= req_y_end;
            hy_ff  <= req_y_start;
            lx_ff  <= req_x_end;
            neg_ff <= req_x_start < req_x_end;
         end
      end
      if (o_load) begin
         o_line_ff  <= line_ext[9:0];
         o_left_ff  <= o_left_in;
         o_right_ff <= o_right_in;
         o_sv_ff    <= o_sv_in;
         o_last_ff  <= o_last_in;
         o_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scanline   = o_line_ff;
   assign rsp_span_left  = o_left_ff;
   assign rsp_span_right = o_right_ff;
   assign rsp_span_valid = o_sv_ff;
   assign rsp_last       = o_last_ff;
   assign rsp_overflow   = o_ovf_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count beyond store depth");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_operation == spf_pkg::OP_CLEAR) |=> (cnt_ff == '0 && line_ff == '0))
      else $error("clear did not empty the store");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_span_valid) |-> (rsp_span_left <= rsp_span_right))
      else $error("span out of order");

   a_pend_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == spf_pkg::ST_WALK))
      else $error("read pending outside the walk");

endmodule
